// ===== design/acra_pkg.sv =====
// ----------------------------------------------------------------------------
// Active-core request arbiter package
// Shared widths, command and register codes, the control-store layout, the
// control-store contents and small arithmetic helpers.
// ----------------------------------------------------------------------------
package acra_pkg;

	// Field widths of one command word and one result word.
	localparam int CMD_W  = 3;
	localparam int TGT_W  = 4;
	localparam int PERF_W = 8;
	localparam int CORE_W = 9;

	// Default number of table entries.
	localparam int MAX_TARGETS_DEF = 16;

	// Configuration bus.
	localparam int APB_AW = 5;
	localparam int APB_DW = 32;

	typedef logic [CORE_W-1:0] cores_t;

	// Command codes.
	localparam logic [CMD_W-1:0] CMD_LIMIT     = 3'd0;
	localparam logic [CMD_W-1:0] CMD_UNLIMIT   = 3'd1;
	localparam logic [CMD_W-1:0] CMD_COMMIT    = 3'd2;
	localparam logic [CMD_W-1:0] CMD_CLEAR     = 3'd3;
	localparam logic [CMD_W-1:0] CMD_CLEAR_ALL = 3'd4;
	localparam logic [CMD_W-1:0] CMD_ADJUST    = 3'd5;

	// Register indexes on the configuration bus.
	typedef enum logic [2:0] {
		REG_CTRL_EN,
		REG_KNOB,
		REG_START,
		REG_STEP_FRAC,
		REG_TOTAL,
		REG_MIN,
		REG_MAX
	} reg_idx_t;

	typedef struct packed {
		logic                  control_enabled;
		logic                  perf_knob_present;
		logic [PERF_W-1:0]     start_pstate;
		cores_t                step_fraction;
		cores_t                total_cores;
		cores_t                min_cores;
		cores_t                max_cores;
	} cfg_t;

	// Program counter of the sequencer.
	typedef enum logic [3:0] {
		PC_FETCH,
		PC_DISPATCH,
		PC_LU_LOAD,
		PC_LU_DONE,
		PC_SCAN,
		PC_DRAIN,
		PC_COMMIT_DONE,
		PC_CLR_ONE,
		PC_CLR_ALL,
		PC_ZERO
	} pc_t;

	typedef enum logic [1:0] {
		RD_NONE,
		RD_TARGET,
		RD_SCAN
	} rd_sel_t;

	typedef enum logic [1:0] {
		RES_ZERO,
		RES_LU,
		RES_COMMIT
	} res_sel_t;

	typedef enum logic [2:0] {
		BR_GO,
		BR_ACCEPT,
		BR_DISPATCH,
		BR_SCAN_END,
		BR_AFTER_SCAN,
		BR_EMIT
	} br_t;

	// One control word.
	typedef struct packed {
		rd_sel_t  rd_sel;
		logic     init;
		logic     load_req;
		logic     lu_write;
		logic     clr_one;
		logic     clr_all;
		logic     emit;
		res_sel_t res_sel;
		br_t      br;
		pc_t      jump;
	} ucode_t;

	// Status from the datapath used by the branch logic.
	typedef struct packed {
		logic             accept;
		logic             tok;
		logic [CMD_W-1:0] cmd;
		logic             scan_last;
		logic             out_free;
	} seq_stat_t;

	// Control store.
	function automatic ucode_t ucode_rom(pc_t pc);
		ucode_t w;
		w = '0;
		unique case (pc)
			PC_FETCH: begin
				w.br   = BR_ACCEPT;
				w.jump = PC_DISPATCH;
			end
			PC_DISPATCH: begin
				w.rd_sel = RD_TARGET;
				w.init   = 1'b1;
				w.br     = BR_DISPATCH;
			end
			PC_LU_LOAD: begin
				w.load_req = 1'b1;
				w.br       = BR_GO;
				w.jump     = PC_LU_DONE;
			end
			PC_LU_DONE: begin
				w.lu_write = 1'b1;
				w.emit     = 1'b1;
				w.res_sel  = RES_LU;
				w.br       = BR_EMIT;
				w.jump     = PC_FETCH;
			end
			PC_SCAN: begin
				w.rd_sel = RD_SCAN;
				w.br     = BR_SCAN_END;
				w.jump   = PC_DRAIN;
			end
			PC_DRAIN: begin
				w.br   = BR_AFTER_SCAN;
				w.jump = PC_COMMIT_DONE;
			end
			PC_COMMIT_DONE: begin
				w.emit    = 1'b1;
				w.res_sel = RES_COMMIT;
				w.br      = BR_EMIT;
				w.jump    = PC_FETCH;
			end
			PC_CLR_ONE: begin
				w.clr_one = 1'b1;
				w.emit    = 1'b1;
				w.br      = BR_EMIT;
				w.jump    = PC_FETCH;
			end
			PC_CLR_ALL: begin
				w.clr_all = 1'b1;
				w.emit    = 1'b1;
				w.br      = BR_EMIT;
				w.jump    = PC_FETCH;
			end
			PC_ZERO: begin
				w.emit = 1'b1;
				w.br   = BR_EMIT;
				w.jump = PC_FETCH;
			end
			default: begin
				w.br   = BR_GO;
				w.jump = PC_FETCH;
			end
		endcase
		return w;
	endfunction

	// Entry point of each command's routine.
	function automatic pc_t dispatch_pc(logic [CMD_W-1:0] cmd, logic tok);
		pc_t pc;
		pc = PC_ZERO;
		unique case (cmd)
			CMD_LIMIT, CMD_UNLIMIT: pc = tok ? PC_LU_LOAD : PC_ZERO;
			CMD_COMMIT, CMD_ADJUST: pc = PC_SCAN;
			CMD_CLEAR:              pc = tok ? PC_CLR_ONE : PC_ZERO;
			CMD_CLEAR_ALL:          pc = PC_CLR_ALL;
			default:                pc = PC_ZERO;
		endcase
		return pc;
	endfunction

	// Floor first, then ceiling, so the ceiling wins when they cross.
	function automatic cores_t clamp_cores(cores_t v, cores_t lo, cores_t hi);
		cores_t r;
		r = (v < lo) ? lo : v;
		r = (r > hi) ? hi : r;
		return r;
	endfunction

endpackage

// ===== design/acra_if.sv =====
// ----------------------------------------------------------------------------
// Active-core request arbiter channels
// Valid/ready channels for command words and result words.
// ----------------------------------------------------------------------------
interface acra_in_if;
	logic                        valid;
	logic                        ready;
	logic [acra_pkg::CMD_W-1:0]  cmd;
	logic [acra_pkg::TGT_W-1:0]  target;
	logic [acra_pkg::PERF_W-1:0] perf_index;
	logic [acra_pkg::CORE_W-1:0] current_active;

	modport source(output valid, cmd, target, perf_index, current_active, input ready);
	modport sink(input valid, cmd, target, perf_index, current_active, output ready);
endinterface

interface acra_out_if;
	logic                        valid;
	logic                        ready;
	logic [acra_pkg::CORE_W-1:0] request_value;
	logic                        applied;
	logic [acra_pkg::CORE_W-1:0] commit_cores;

	modport source(output valid, request_value, applied, commit_cores, input ready);
	modport sink(input valid, request_value, applied, commit_cores, output ready);
endinterface

// ===== design/acra_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module acra_ram #(
	parameter int WIDTH = 9,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== design/acra_seq.sv =====
// ----------------------------------------------------------------------------
// Active-core request arbiter sequencer
// Program counter, control store lookup and branch logic.
// ----------------------------------------------------------------------------
module acra_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  acra_pkg::seq_stat_t stat,
	output acra_pkg::ucode_t    cw
);
	import acra_pkg::*;

	pc_t pc_q;
	pc_t pc_d;

	// Program counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_FETCH;
		end else begin
			pc_q <= pc_d;
		end
	end

	// Control word of the current step.
	assign cw = ucode_rom(pc_q);

	// Next step to run.
	always_comb begin
		pc_d = pc_q;
		unique case (cw.br)
			BR_GO:         pc_d = cw.jump;
			BR_ACCEPT:     pc_d = stat.accept ? cw.jump : pc_q;
			BR_DISPATCH:   pc_d = dispatch_pc(stat.cmd, stat.tok);
			BR_SCAN_END:   pc_d = stat.scan_last ? cw.jump : pc_q;
			BR_AFTER_SCAN: pc_d = (stat.cmd == CMD_COMMIT) ? cw.jump : PC_ZERO;
			BR_EMIT:       pc_d = stat.out_free ? cw.jump : pc_q;
			default:       pc_d = PC_FETCH;
		endcase
	end

endmodule

// ===== design/acra_dp.sv =====
// ----------------------------------------------------------------------------
// Active-core request arbiter datapath
// Command register, request table with valid bits, step arithmetic, table
// walk for commit and adjust, and the result register.
// ----------------------------------------------------------------------------
module acra_dp #(
	parameter int MAX_TARGETS = acra_pkg::MAX_TARGETS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  acra_pkg::cfg_t       cfg,
	input  acra_pkg::ucode_t     cw,
	output acra_pkg::seq_stat_t  stat,
	acra_in_if.sink              item,
	acra_out_if.source           result
);
	import acra_pkg::*;

	localparam int IDX_W = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;

	// Held command word.
	logic [CMD_W-1:0]  cmd_q;
	logic [TGT_W-1:0]  tgt_q;
	logic [PERF_W-1:0] perf_q;
	cores_t            cur_q;

	logic              accept;
	logic              tok;
	logic [IDX_W-1:0]  tgt_idx;

	// Table state and walk.
	logic [MAX_TARGETS-1:0] valid_q;
	logic [IDX_W-1:0]       idx_q;
	logic [IDX_W-1:0]       ridx_s1;
	logic                   pend_s1;
	logic                   any_q;
	cores_t                 low_q;

	// Memory ports.
	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	cores_t           ram_wdata;
	logic             ram_re;
	logic [IDX_W-1:0] ram_raddr;
	cores_t           ram_rdata;

	// Limit and unlimit arithmetic.
	logic [2*CORE_W-1:0] prod;
	logic [2*CORE_W:0]   prod_rnd;
	cores_t              req_q;
	cores_t              step_q;
	logic [PERF_W-1:0]   pi;
	logic                lim_ok;
	logic                unl_ok;
	logic [CORE_W:0]     floor_sum;
	logic [CORE_W:0]     ceil_sum;
	cores_t              lim_nx;
	cores_t              unl_nx;
	logic                lu_ap;
	cores_t              lu_rv;
	logic                is_limit;

	// Commit result.
	cores_t cm_rv;
	logic   cm_ap;

	// Scan hit and output register.
	logic   scan_hit;
	logic   out_free;
	logic   out_load;
	logic   out_valid_q;
	cores_t out_rv_q;
	logic   out_ap_q;
	cores_t out_cc_q;

	// Command intake.
	assign item.ready = (cw.br == BR_ACCEPT);
	assign accept     = item.valid && item.ready;

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= item.cmd;
			tgt_q  <= item.target;
			perf_q <= item.perf_index;
			cur_q  <= item.current_active;
		end
	end

	assign tok     = (32'(tgt_q) < 32'(MAX_TARGETS));
	assign tgt_idx = IDX_W'(tgt_q);

	// Status for the branch logic.
	assign out_free       = !out_valid_q || result.ready;
	assign out_load       = cw.emit && out_free;
	assign stat.accept    = accept;
	assign stat.tok       = tok;
	assign stat.cmd       = cmd_q;
	assign stat.scan_last = (idx_q == IDX_W'(MAX_TARGETS - 1));
	assign stat.out_free  = out_free;

	// Walk index and read pipeline tracking.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			pend_s1 <= 1'b0;
		end else begin
			if (cw.init) begin
				idx_q <= '0;
			end else if (cw.rd_sel == RD_SCAN) begin
				idx_q <= idx_q + IDX_W'(1);
			end
			pend_s1 <= (cw.rd_sel == RD_SCAN);
		end
	end

	always_ff @(posedge clk) begin
		ridx_s1 <= idx_q;
	end

	assign scan_hit = pend_s1 && valid_q[ridx_s1];

	// Running minimum over valid entries for commit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			any_q <= 1'b0;
		end else if (cw.init) begin
			any_q <= 1'b0;
		end else if (scan_hit && (cmd_q == CMD_COMMIT) && (!any_q || ram_rdata < low_q)) begin
			any_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (scan_hit && (cmd_q == CMD_COMMIT) && (!any_q || ram_rdata < low_q)) begin
			low_q <= ram_rdata;
		end
	end

	// Step size and the target's current request.
	assign prod     = (2*CORE_W)'(cfg.step_fraction) * (2*CORE_W)'(cfg.total_cores);
	assign prod_rnd = {1'b0, prod} + (2*CORE_W+1)'(255);

	always_ff @(posedge clk) begin
		if (cw.load_req) begin
			req_q  <= valid_q[tgt_idx] ? ram_rdata : cfg.max_cores;
			step_q <= prod_rnd[CORE_W+7:8];
		end
	end

	// New request for limit and unlimit.
	always_comb begin
		is_limit  = (cmd_q == CMD_LIMIT);
		pi        = cfg.perf_knob_present ? perf_q : cfg.start_pstate;
		lim_ok    = (pi >= cfg.start_pstate) && (req_q > cfg.min_cores);
		unl_ok    = (req_q < cfg.max_cores);
		floor_sum = {1'b0, step_q} + {1'b0, cfg.min_cores};
		ceil_sum  = {1'b0, req_q} + {1'b0, step_q};
		lim_nx    = ({1'b0, req_q} < floor_sum) ? cfg.min_cores : (req_q - step_q);
		unl_nx    = (ceil_sum > {1'b0, cfg.max_cores}) ? cfg.max_cores : ceil_sum[CORE_W-1:0];
		lu_ap     = cfg.control_enabled && (is_limit ? lim_ok : unl_ok);
		lu_rv     = lu_ap ? (is_limit ? lim_nx : unl_nx) : req_q;
	end

	// Commit value: lowest request or current count, clamped.
	assign cm_rv = clamp_cores(any_q ? low_q : cur_q, cfg.min_cores, cfg.max_cores);
	assign cm_ap = cfg.control_enabled && (cm_rv != cur_q);

	// Memory access: limit and unlimit write back, adjust rewrites the walk.
	always_comb begin
		ram_re    = (cw.rd_sel != RD_NONE);
		ram_raddr = (cw.rd_sel == RD_TARGET) ? tgt_idx : idx_q;
		if (cw.lu_write) begin
			ram_we    = lu_ap;
			ram_waddr = tgt_idx;
			ram_wdata = lu_rv;
		end else begin
			ram_we    = scan_hit && (cmd_q == CMD_ADJUST);
			ram_waddr = ridx_s1;
			ram_wdata = clamp_cores(ram_rdata, cfg.min_cores, cfg.max_cores);
		end
	end

	acra_ram #(
		.WIDTH (CORE_W),
		.DEPTH (MAX_TARGETS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cw.clr_all) begin
			valid_q <= '0;
		end else if (cw.clr_one) begin
			valid_q[tgt_idx] <= 1'b0;
		end else if (cw.lu_write && lu_ap) begin
			valid_q[tgt_idx] <= 1'b1;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			unique case (cw.res_sel)
				RES_LU: begin
					out_rv_q <= lu_rv;
					out_ap_q <= lu_ap;
					out_cc_q <= '0;
				end
				RES_COMMIT: begin
					out_rv_q <= cm_rv;
					out_ap_q <= cm_ap;
					out_cc_q <= cm_ap ? cm_rv : '0;
				end
				default: begin
					out_rv_q <= '0;
					out_ap_q <= 1'b0;
					out_cc_q <= '0;
				end
			endcase
		end
	end

	assign result.valid         = out_valid_q;
	assign result.request_value = out_rv_q;
	assign result.applied       = out_ap_q;
	assign result.commit_cores  = out_cc_q;

`ifndef ASSERT_OFF
	// A core count is only handed out with an applied commit.
	a_cc_needs_ap: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.applied) |-> (result.commit_cores == '0))
		else $error("commit_cores set without applied");

	// A handed-out core count never exceeds the ceiling.
	a_cc_ceiling: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.applied && (result.commit_cores != '0))
		|-> (result.commit_cores <= cfg.max_cores))
		else $error("commit_cores above max_cores");

	// Clear-all leaves the table empty.
	a_clr_all: assert property (@(posedge clk) disable iff (!arst_n)
		cw.clr_all |=> (valid_q == '0))
		else $error("table not empty after clear-all");

	// The walk steps one entry per cycle.
	a_walk_step: assert property (@(posedge clk) disable iff (!arst_n)
		((cw.rd_sel == RD_SCAN) && !stat.scan_last) |=> (idx_q == $past(idx_q) + IDX_W'(1)))
		else $error("table walk skipped an entry");
`endif

endmodule

// ===== design/active_core_request_arbiter_core.sv =====
// Order: limit and unlimit read the target's entry, load the request, then write back and
// give their result word; clears give theirs directly; commit and adjust walk the table first.
// A new command word is taken only once the result word of the last one is loaded into the
// result register; commit and adjust are slowed by the walk over the single read port.
// Reset: arst_n clears the sequencer, registers take their reset values, table empty.
// ----------------------------------------------------------------------------
// Active-core request arbiter
// Configuration registers on an APB-style port, microcoded sequencer and
// datapath that keep and arbitrate per-target active-core requests.
// ----------------------------------------------------------------------------
module active_core_request_arbiter_core #(
	parameter int MAX_TARGETS = acra_pkg::MAX_TARGETS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [acra_pkg::APB_AW-1:0] paddr,
	input  logic [acra_pkg::APB_DW-1:0] pwdata,
	output logic [acra_pkg::APB_DW-1:0] prdata,
	output logic                        pready,
	acra_in_if.sink                     item,
	acra_out_if.source                  result
);
	import acra_pkg::*;

	cfg_t      cfg_q;
	reg_idx_t  reg_idx;
	logic      wr_en;
	ucode_t    cw;
	seq_stat_t stat;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[APB_AW-1:2]);
	assign wr_en   = psel && penable && pwrite && pready;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.control_enabled   <= 1'b0;
			cfg_q.perf_knob_present <= 1'b0;
			cfg_q.start_pstate      <= '0;
			cfg_q.step_fraction     <= '0;
			cfg_q.total_cores       <= CORE_W'(1);
			cfg_q.min_cores         <= '0;
			cfg_q.max_cores         <= CORE_W'(256);
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_CTRL_EN:   cfg_q.control_enabled   <= pwdata[0];
				REG_KNOB:      cfg_q.perf_knob_present <= pwdata[0];
				REG_START:     cfg_q.start_pstate      <= pwdata[PERF_W-1:0];
				REG_STEP_FRAC: cfg_q.step_fraction     <= pwdata[CORE_W-1:0];
				REG_TOTAL:     cfg_q.total_cores       <= pwdata[CORE_W-1:0];
				REG_MIN:       cfg_q.min_cores         <= pwdata[CORE_W-1:0];
				REG_MAX:       cfg_q.max_cores         <= pwdata[CORE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Register read back.
	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			REG_CTRL_EN:   prdata = APB_DW'(cfg_q.control_enabled);
			REG_KNOB:      prdata = APB_DW'(cfg_q.perf_knob_present);
			REG_START:     prdata = APB_DW'(cfg_q.start_pstate);
			REG_STEP_FRAC: prdata = APB_DW'(cfg_q.step_fraction);
			REG_TOTAL:     prdata = APB_DW'(cfg_q.total_cores);
			REG_MIN:       prdata = APB_DW'(cfg_q.min_cores);
			REG_MAX:       prdata = APB_DW'(cfg_q.max_cores);
			default:       prdata = '0;
		endcase
	end

	acra_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.cw     (cw)
	);

	acra_dp #(
		.MAX_TARGETS (MAX_TARGETS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.cw     (cw),
		.stat   (stat),
		.item   (item),
		.result (result)
	);

endmodule

// ===== sim/tb_active_core_request_arbiter_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Active-core request arbiter testbench
// Drives command words into the arbiter and keeps its own copy of the
// per-target request table. It predicts each result word when the command
// word is taken, and the monitor compares each result word with the oldest
// prediction. Configuration is rewritten over the APB port between phases.
// ----------------------------------------------------------------------------
module tb_active_core_request_arbiter_core;
	import acra_pkg::*;

	localparam int MAX_T     = MAX_TARGETS_DEF;
	localparam int IDLE_TAIL = 40;
	localparam int LONG_HOLD = 400;

	// Command codes that the block treats as no operation.
	localparam logic [CMD_W-1:0] CMD_SPARE6 = 3'd6;
	localparam logic [CMD_W-1:0] CMD_SPARE7 = 3'd7;

	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [TGT_W-1:0]  target;
		logic [PERF_W-1:0] perf_index;
		cores_t            current_active;
	} cmd_word_t;

	typedef struct packed {
		cores_t request_value;
		logic   applied;
		cores_t commit_cores;
	} res_word_t;

	logic              clk     = 1'b0;
	logic              arst_n  = 1'b0;
	logic              psel    = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite  = 1'b0;
	logic [APB_AW-1:0] paddr   = '0;
	logic [APB_DW-1:0] pwdata  = '0;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	logic      drv_valid = 1'b0;
	cmd_word_t drv_word  = '0;
	logic      rx_ready  = 1'b0;

	cmd_word_t cmd_backlog[$];
	res_word_t result_due[$];

	int unsigned tx_gap        = 0;
	int unsigned rx_stall      = 0;
	int unsigned rx_long_reqs  = 0;
	int unsigned rx_long_seen  = 0;
	bit          tx_no_gap     = 1'b0;
	bit          rx_no_gap     = 1'b0;
	int          errors        = 0;

	// Shadow of the configuration registers and of the request table.
	cfg_t shadow = '{control_enabled: 1'b0, perf_knob_present: 1'b0, start_pstate: '0,
		step_fraction: '0, total_cores: 9'd1, min_cores: '0, max_cores: 9'd256};
	bit     used_tab  [MAX_T];
	cores_t cores_tab [MAX_T];

	acra_in_if  item_ch();
	acra_out_if result_ch();

	assign item_ch.valid          = drv_valid;
	assign item_ch.cmd            = drv_word.cmd;
	assign item_ch.target         = drv_word.target;
	assign item_ch.perf_index     = drv_word.perf_index;
	assign item_ch.current_active = drv_word.current_active;
	assign result_ch.ready        = rx_ready;

	active_core_request_arbiter_core u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.item    (item_ch),
		.result  (result_ch)
	);

	// Free-running clock.
	initial begin
		forever #10 clk = ~clk;
	end

	// Idle stretch length: mostly none or short, now and then long.
	function automatic int unsigned idle_span();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Core count with the range ends picked more often than the inside.
	function automatic int unsigned pick_count(int unsigned lo, int unsigned hi);
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return lo;
		if (r == 1)
			return hi;
		return $urandom_range(lo, hi);
	endfunction

	// Floor first, then ceiling, so the ceiling wins when the two cross.
	function automatic int clamp_to_range(int v);
		int mn;
		int mx;
		mn = shadow.min_cores;
		mx = shadow.max_cores;
		if (v < mn)
			v = mn;
		if (v > mx)
			v = mx;
		return v;
	endfunction

	// Applies one command word to the shadow table and returns its result word.
	function automatic res_word_t arbitrate(cmd_word_t w);
		res_word_t r;
		int        req;
		int        stp;
		int        nx;
		int        pi;
		int        mn;
		int        mx;
		int        low;
		int        cur;
		bit        any;
		r   = '0;
		mn  = shadow.min_cores;
		mx  = shadow.max_cores;
		cur = w.current_active;
		stp = (int'(shadow.step_fraction) * int'(shadow.total_cores) + 255) >>> 8;
		case (w.cmd)
			CMD_LIMIT, CMD_UNLIMIT: begin
				req = used_tab[w.target] ? int'(cores_tab[w.target]) : mx;
				r.request_value = cores_t'(req);
				if (shadow.control_enabled) begin
					if (w.cmd == CMD_LIMIT) begin
						pi = shadow.perf_knob_present ? int'(w.perf_index)
							: int'(shadow.start_pstate);
						if (pi >= int'(shadow.start_pstate) && req > mn) begin
							nx = req - stp;
							if (nx < mn)
								nx = mn;
							r.request_value = cores_t'(nx);
							r.applied = 1'b1;
						end
					end else if (req < mx) begin
						nx = req + stp;
						if (nx > mx)
							nx = mx;
						r.request_value = cores_t'(nx);
						r.applied = 1'b1;
					end
					if (r.applied) begin
						cores_tab[w.target] = r.request_value;
						used_tab[w.target]  = 1'b1;
					end
				end
			end
			CMD_COMMIT: begin
				any = 1'b0;
				low = 0;
				for (int i = 0; i < MAX_T; i++) begin
					if (used_tab[i] && (!any || int'(cores_tab[i]) < low)) begin
						low = cores_tab[i];
						any = 1'b1;
					end
				end
				nx = clamp_to_range(any ? low : cur);
				r.request_value = cores_t'(nx);
				if (shadow.control_enabled && nx != cur) begin
					r.applied      = 1'b1;
					r.commit_cores = cores_t'(nx);
				end
			end
			CMD_CLEAR: begin
				used_tab[w.target] = 1'b0;
			end
			CMD_CLEAR_ALL: begin
				for (int i = 0; i < MAX_T; i++)
					used_tab[i] = 1'b0;
			end
			CMD_ADJUST: begin
				for (int i = 0; i < MAX_T; i++)
					if (used_tab[i])
						cores_tab[i] = cores_t'(clamp_to_range(cores_tab[i]));
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	// Command side: offers words from the backlog and predicts each taken word.
	always @(posedge clk) begin : cmd_driver
		bit          taken;
		int unsigned g;
		if (!arst_n) begin
			drv_valid <= 1'b0;
			tx_gap    <= 0;
		end else begin
			taken = drv_valid && item_ch.ready;
			if (taken)
				result_due.push_back(arbitrate(drv_word));
			g = tx_gap;
			if (taken)
				g = tx_no_gap ? 0 : idle_span();
			if (drv_valid && !taken) begin
				// Keep offering the same word until it is taken.
			end else if (g != 0) begin
				drv_valid <= 1'b0;
				tx_gap    <= g - 1;
			end else if (cmd_backlog.size() != 0) begin
				drv_word  <= cmd_backlog.pop_front();
				drv_valid <= 1'b1;
				tx_gap    <= 0;
			end else begin
				drv_valid <= 1'b0;
				tx_gap    <= 0;
			end
		end
	end

	// Result side: checks each taken result word and throttles ready.
	always @(posedge clk) begin : res_monitor
		res_word_t   exp_w;
		int unsigned g;
		if (!arst_n) begin
			rx_ready <= 1'b0;
			rx_stall <= 0;
		end else begin
			if (result_ch.valid && rx_ready) begin
				if (result_due.size() == 0) begin
					$error("result word with no prediction waiting");
					errors++;
				end else begin
					exp_w = result_due.pop_front();
					if (result_ch.request_value !== exp_w.request_value) begin
						$error("request_value: expected %0d, actual %0d",
							exp_w.request_value, result_ch.request_value);
						errors++;
					end
					if (result_ch.applied !== exp_w.applied) begin
						$error("applied: expected %0d, actual %0d",
							exp_w.applied, result_ch.applied);
						errors++;
					end
					if (result_ch.commit_cores !== exp_w.commit_cores) begin
						$error("commit_cores: expected %0d, actual %0d",
							exp_w.commit_cores, result_ch.commit_cores);
						errors++;
					end
				end
			end
			if (rx_long_seen != rx_long_reqs) begin
				rx_long_seen <= rx_long_reqs;
				rx_stall     <= LONG_HOLD;
				rx_ready     <= 1'b0;
			end else if (rx_stall != 0) begin
				rx_stall <= rx_stall - 1;
				rx_ready <= (rx_stall == 1);
			end else if (result_ch.valid && rx_ready && !rx_no_gap) begin
				g = idle_span();
				rx_stall <= g;
				rx_ready <= (g == 0);
			end else begin
				rx_ready <= 1'b1;
			end
		end
	end

	// One APB write: setup cycle, then access cycle, then release.
	task automatic write_reg(reg_idx_t r, int unsigned v);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {r, 2'b00};
		pwdata  <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (r)
			REG_CTRL_EN:   shadow.control_enabled   = v[0];
			REG_KNOB:      shadow.perf_knob_present = v[0];
			REG_START:     shadow.start_pstate      = v[PERF_W-1:0];
			REG_STEP_FRAC: shadow.step_fraction     = cores_t'(v);
			REG_TOTAL:     shadow.total_cores       = cores_t'(v);
			REG_MIN:       shadow.min_cores         = cores_t'(v);
			REG_MAX:       shadow.max_cores         = cores_t'(v);
			default: begin
			end
		endcase
	endtask

	task automatic queue_word(logic [CMD_W-1:0] c, int unsigned t, int unsigned p,
		int unsigned cur);
		cmd_word_t w;
		w.cmd            = c;
		w.target         = t[TGT_W-1:0];
		w.perf_index     = p[PERF_W-1:0];
		w.current_active = cores_t'(cur);
		cmd_backlog.push_back(w);
	endtask

	// Waits until every word is sent and every result word is back, then idles.
	task automatic drain();
		while (cmd_backlog.size() != 0 || drv_valid || result_due.size() != 0)
			@(posedge clk);
		repeat (IDLE_TAIL) @(posedge clk);
	endtask

	// Main sequence: reset, directed phases, then random phases.
	initial begin : main_seq
		int unsigned r;
		int unsigned lo;
		int unsigned hi;
		int unsigned st;
		int unsigned t;
		int unsigned p;
		logic [CMD_W-1:0] c;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		// Reset settings: control off, so limit and unlimit change nothing.
		queue_word(CMD_LIMIT, 0, 255, 0);
		queue_word(CMD_UNLIMIT, 1, 0, 0);
		queue_word(CMD_COMMIT, 0, 0, 0);
		queue_word(CMD_COMMIT, 0, 0, 256);
		queue_word(CMD_CLEAR, 2, 0, 0);
		queue_word(CMD_CLEAR_ALL, 0, 0, 0);
		queue_word(CMD_ADJUST, 0, 0, 0);
		queue_word(CMD_SPARE6, 15, 255, 256);
		queue_word(CMD_SPARE7, 15, 255, 256);
		drain();

		// Step of four between two and twelve; walk to the floor and back up.
		write_reg(REG_CTRL_EN, 1);
		write_reg(REG_KNOB, 1);
		write_reg(REG_START, 128);
		write_reg(REG_STEP_FRAC, 64);
		write_reg(REG_TOTAL, 16);
		write_reg(REG_MIN, 2);
		write_reg(REG_MAX, 12);
		queue_word(CMD_LIMIT, 0, 255, 0);
		queue_word(CMD_LIMIT, 0, 127, 0);
		queue_word(CMD_LIMIT, 0, 128, 0);
		queue_word(CMD_LIMIT, 0, 200, 0);
		queue_word(CMD_LIMIT, 0, 255, 0);
		queue_word(CMD_UNLIMIT, 0, 0, 0);
		queue_word(CMD_UNLIMIT, 5, 0, 0);
		queue_word(CMD_COMMIT, 0, 0, 0);
		queue_word(CMD_CLEAR, 0, 0, 0);
		queue_word(CMD_COMMIT, 0, 0, 256);
		drain();

		// Zero step still writes the entry; then floor above ceiling.
		write_reg(REG_STEP_FRAC, 0);
		queue_word(CMD_LIMIT, 2, 255, 0);
		drain();
		write_reg(REG_MIN, 200);
		write_reg(REG_MAX, 100);
		queue_word(CMD_ADJUST, 0, 0, 0);
		queue_word(CMD_COMMIT, 0, 0, 100);
		drain();

		// Full-width step, no performance knob, widest range.
		write_reg(REG_KNOB, 0);
		write_reg(REG_START, 255);
		write_reg(REG_STEP_FRAC, 256);
		write_reg(REG_TOTAL, 256);
		write_reg(REG_MIN, 0);
		write_reg(REG_MAX, 256);
		queue_word(CMD_LIMIT, 15, 0, 0);
		queue_word(CMD_UNLIMIT, 15, 0, 0);
		queue_word(CMD_COMMIT, 0, 0, 0);
		drain();

		// Random phases, each with its own settings.
		for (int ph = 0; ph < 6; ph++) begin
			write_reg(REG_CTRL_EN, ($urandom_range(0, 3) != 0));
			write_reg(REG_KNOB, $urandom_range(0, 1));
			st = pick_count(0, 255);
			write_reg(REG_START, st);
			write_reg(REG_STEP_FRAC, pick_count(0, 256));
			write_reg(REG_TOTAL, pick_count(1, 256));
			lo = pick_count(0, 256);
			hi = pick_count(0, 256);
			if (lo > hi && $urandom_range(0, 4) != 0) begin
				r  = lo;
				lo = hi;
				hi = r;
			end
			write_reg(REG_MIN, lo);
			write_reg(REG_MAX, hi);

			if (ph == 2) begin
				// Receiver holds off while the sender keeps offering.
				tx_no_gap = 1'b1;
				rx_long_reqs++;
			end else if (ph == 4) begin
				tx_no_gap = 1'b1;
				rx_no_gap = 1'b1;
			end

			for (int n = 0; n < 150; n++) begin
				r = $urandom_range(0, 99);
				if (r < 38)
					c = CMD_LIMIT;
				else if (r < 70)
					c = CMD_UNLIMIT;
				else if (r < 82)
					c = CMD_COMMIT;
				else if (r < 87)
					c = CMD_ADJUST;
				else if (r < 93)
					c = CMD_CLEAR;
				else if (r < 96)
					c = CMD_CLEAR_ALL;
				else
					c = $urandom_range(0, 1) ? CMD_SPARE6 : CMD_SPARE7;
				t = $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, 15);
				// Half the time the performance index is drawn at or past the start index.
				p = $urandom_range(0, 1) ? $urandom_range(st, 255) : $urandom_range(0, 255);
				queue_word(c, t, p, pick_count(0, 256));
			end
			drain();
			tx_no_gap = 1'b0;
			rx_no_gap = 1'b0;
		end

		if (result_due.size() != 0)
			errors++;
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Run limit, well above the slowest correct run.
	initial begin : watchdog
		#15_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
